@@ design/assert_macros.svh @@
// Assertion macros shared by the quantizer RTL modules.
// Simulation builds get concurrent assertions; synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising clock edge outside reset.
`define UQD_ASSERT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("uqd: assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define UQD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("uqd: assertion failed");

`else

`define UQD_ASSERT(label, clk, rstn, ante, cons)
`define UQD_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

@@ design/uqd_pkg.sv @@
// Shared types and constants of the uniform quantize/dequantize unit.
// Used by the register block, the controller, the datapath and the top level.
package uqd_pkg;

    // Default sizes of the stream fields.
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int SYMBOL_BITS_DEF = 16;

    // Fixed field widths.
    localparam int STEP_BITS   = 23;
    localparam int MAXIDX_BITS = 15;
    localparam int INDEX_BITS  = 16;
    localparam int DIST_BITS   = 62;

    // Configuration port.
    localparam int CFG_ADDR_BITS = 4;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [1:0] REG_STEP_SIZE = 2'd0;
    localparam logic [1:0] REG_MIN_STEP  = 2'd1;
    localparam logic [1:0] REG_MAX_INDEX = 2'd2;
    localparam logic [1:0] REG_MIN_INDEX = 2'd3;

    localparam logic [STEP_BITS-1:0] STEP_SIZE_RST = 23'd256;

    // Request kinds carried on s_tuser.
    localparam logic FUNC_QUANT   = 1'b0;
    localparam logic FUNC_DEQUANT = 1'b1;

    // Saturation value of the squared-error sum.
    localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

    // Configuration register contents.
    typedef struct packed {
        logic [STEP_BITS-1:0]   step_size;
        logic [STEP_BITS-1:0]   min_step;
        logic [MAXIDX_BITS-1:0] max_index;
        logic [INDEX_BITS-1:0]  min_index;
    } uqd_cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic div_step;
        logic sym_step;
        logic ksel_step;
        logic mul_step;
        logic recon_step;
        logic err_step;
        logic sq_step;
        logic acc_step;
        logic out_load;
    } uqd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_func;
        logic step_bad;
    } uqd_stat_t;

endpackage

@@ design/uqd_regs.sv @@
// APB-style configuration registers of the quantizer.
// Depends on uqd_pkg for the register map and the configuration struct.
module uqd_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [uqd_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [uqd_pkg::CFG_DATA_BITS-1:0]  pwdata,
    output logic [uqd_pkg::CFG_DATA_BITS-1:0]  prdata,
    output logic                               pready,
    output uqd_pkg::uqd_cfg_t                  cfg
);
    import uqd_pkg::*;

    uqd_cfg_t   cfg_reg;
    logic [1:0] reg_sel;
    logic       wr_en;

    // Registers sit on word boundaries.
    assign reg_sel = paddr[CFG_ADDR_BITS-1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign cfg     = cfg_reg;

    // Register writes in the access phase.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_size <= STEP_SIZE_RST;
            cfg_reg.min_step  <= '0;
            cfg_reg.max_index <= '0;
            cfg_reg.min_index <= '0;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_STEP_SIZE: cfg_reg.step_size <= pwdata[STEP_BITS-1:0];
                REG_MIN_STEP:  cfg_reg.min_step  <= pwdata[STEP_BITS-1:0];
                REG_MAX_INDEX: cfg_reg.max_index <= pwdata[MAXIDX_BITS-1:0];
                REG_MIN_INDEX: cfg_reg.min_index <= pwdata[INDEX_BITS-1:0];
            endcase
        end
    end

    // Read-back of the selected register.
    always_comb begin
        unique case (reg_sel)
            REG_STEP_SIZE: prdata = CFG_DATA_BITS'(cfg_reg.step_size);
            REG_MIN_STEP:  prdata = CFG_DATA_BITS'(cfg_reg.min_step);
            REG_MAX_INDEX: prdata = CFG_DATA_BITS'(cfg_reg.max_index);
            REG_MIN_INDEX: prdata = CFG_DATA_BITS'(cfg_reg.min_index);
        endcase
    end

endmodule

@@ design/uqd_ctrl.sv @@
// Controller state machine of the quantizer: sequences one request at a time.
// Depends on uqd_pkg for command/status structs and assert_macros.svh.
`include "assert_macros.svh"

module uqd_ctrl #(
    parameter int SAMPLE_BITS = uqd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  uqd_pkg::uqd_stat_t  stat,
    output uqd_pkg::uqd_cmd_t   cmd
);
    import uqd_pkg::*;

    localparam int CNT_BITS = $clog2(SAMPLE_BITS);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIV   = 4'd1;
    localparam logic [3:0] S_SYM   = 4'd2;
    localparam logic [3:0] S_KSEL  = 4'd3;
    localparam logic [3:0] S_MUL   = 4'd4;
    localparam logic [3:0] S_RECON = 4'd5;
    localparam logic [3:0] S_ERR   = 4'd6;
    localparam logic [3:0] S_SQ    = 4'd7;
    localparam logic [3:0] S_ACC   = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0]          state_reg, state_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                func_reg, func_next;
    logic                m_valid_reg, m_valid_next;
    logic                accept;
    logic                slot_free;

    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign accept    = s_tvalid & s_tready;
    assign slot_free = !m_valid_reg || m_tready;

    // Next-state and command decode.
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        func_next  = func_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd.load_in = 1'b1;
                    func_next   = stat.in_func;
                    cnt_next    = CNT_BITS'(SAMPLE_BITS - 1);
                    if (stat.in_func == FUNC_DEQUANT) begin
                        state_next = S_SYM;
                    end else if (stat.step_bad) begin
                        state_next = S_ACC;
                    end else begin
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0) begin
                    state_next = S_SYM;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_SYM: begin
                cmd.sym_step = 1'b1;
                state_next   = S_KSEL;
            end
            S_KSEL: begin
                cmd.ksel_step = 1'b1;
                state_next    = S_MUL;
            end
            S_MUL: begin
                cmd.mul_step = 1'b1;
                state_next   = S_RECON;
            end
            S_RECON: begin
                cmd.recon_step = 1'b1;
                state_next     = (func_reg == FUNC_DEQUANT) ? S_ACC : S_ERR;
            end
            S_ERR: begin
                cmd.err_step = 1'b1;
                state_next   = S_SQ;
            end
            S_SQ: begin
                cmd.sq_step = 1'b1;
                state_next  = S_ACC;
            end
            S_ACC: begin
                cmd.acc_step = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT: begin
                if (slot_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Output valid: set on load, cleared when the result is taken.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            func_reg    <= FUNC_QUANT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            func_reg    <= func_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // A result is only loaded when the output register is free or draining.
    `UQD_ASSERT(a_load_into_free_slot, aclk, aresetn, cmd.out_load, (!m_valid_reg || m_tready))
    // An accepted request always starts processing.
    `UQD_ASSERT_NEXT(a_accept_leaves_idle, aclk, aresetn, accept, (state_reg != S_IDLE))
    // The divider finishes after its last quotient bit.
    `UQD_ASSERT_NEXT(a_div_ends, aclk, aresetn, (state_reg == S_DIV && cnt_reg == '0),
        (state_reg == S_SYM))

endmodule

@@ design/uqd_dp.sv @@
// Datapath of the quantizer: divider, symbol mapping, midpoint reconstruction,
// squared-error accumulator and output register. Depends on uqd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module uqd_dp #(
    parameter int SAMPLE_BITS = uqd_pkg::SAMPLE_BITS_DEF,
    parameter int SYMBOL_BITS = uqd_pkg::SYMBOL_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  uqd_pkg::uqd_cfg_t                      cfg,
    input  uqd_pkg::uqd_cmd_t                      cmd,
    output uqd_pkg::uqd_stat_t                     stat,
    // s_tdata: sample, symbol_in (lowest bit first), zero padded
    input  logic [((SAMPLE_BITS + SYMBOL_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // s_tuser: func
    input  logic                                   s_tuser,
    input  logic                                   s_tlast,
    // m_tdata: symbol_out, value, distortion_sum (lowest bit first), zero padded
    output logic [((SYMBOL_BITS + SAMPLE_BITS + uqd_pkg::DIST_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    // m_tuser: rejected
    output logic                                   m_tuser,
    output logic                                   m_tlast
);
    import uqd_pkg::*;

    localparam int OUT_W = ((SYMBOL_BITS + SAMPLE_BITS + DIST_BITS + 7) / 8) * 8;
    localparam int KW    = ((SYMBOL_BITS > INDEX_BITS) ? SYMBOL_BITS : INDEX_BITS) + 2;
    localparam int PW    = KW + 1 + STEP_BITS + 1;
    localparam int WIDE0 = (SAMPLE_BITS > SYMBOL_BITS) ? SAMPLE_BITS : SYMBOL_BITS;
    localparam int SVW   = ((WIDE0 > INDEX_BITS) ? WIDE0 : INDEX_BITS) + 2;
    localparam int DW    = SAMPLE_BITS + 1;

    // Request fields.
    logic                          func_reg, last_reg, rej_reg;
    logic [SAMPLE_BITS-1:0]        x_reg;
    logic [SYMBOL_BITS-1:0]        symin_reg;
    logic [SAMPLE_BITS-1:0]        in_sample, in_mag;
    logic [SYMBOL_BITS-1:0]        in_symbol;

    // Divider.
    logic [STEP_BITS-1:0]          rem_reg, rem_next;
    logic [SAMPLE_BITS-1:0]        quo_reg, quo_next;
    logic [STEP_BITS:0]            trial;
    logic                          trial_ge;

    // Symbol and index selection.
    logic                          both_zero, offset_mode, x_neg;
    logic signed [SVW-1:0]         q_w, imin_w, imax_w, sv;
    logic [SYMBOL_BITS-1:0]        sym_reg, sym_q, sym_next;
    logic signed [KW-1:0]          s_k, imin_k, imax_k, n_k, thr_k, k_reg, k_next;
    logic                          vzero_reg, vzero_next, neg_reg, neg_next;

    // Midpoint product and reconstruction.
    logic signed [KW:0]            odd_w;
    logic signed [STEP_BITS:0]     step_w;
    logic signed [PW-1:0]          prod_reg, prod_next, mp, val;
    logic [PW-SAMPLE_BITS:0]       val_top;
    logic [SAMPLE_BITS-1:0]        v_reg, v_next, v_sat;

    // Error and accumulator.
    logic [DW-1:0]                 d_w, ad_w;
    logic [32:0]                   ad_reg;
    logic [30:0]                   ad_lo;
    logic [DIST_BITS-1:0]          sq_reg, sq_next;
    logic                          big_reg;
    logic [DIST_BITS:0]            sum_w;
    logic [DIST_BITS-1:0]          acc_reg, acc_new, dist_reg;

    // Output register.
    logic [OUT_W-1:0]              m_tdata_reg;
    logic                          m_tuser_reg, m_tlast_reg;
    logic [SYMBOL_BITS-1:0]        sym_out;
    logic [SAMPLE_BITS-1:0]        v_out;

    // Incoming request fields and status for the controller.
    assign in_sample     = s_tdata[SAMPLE_BITS-1:0];
    assign in_symbol     = s_tdata[SAMPLE_BITS+SYMBOL_BITS-1:SAMPLE_BITS];
    assign in_mag        = in_sample[SAMPLE_BITS-1] ? (~in_sample + 1'b1) : in_sample;
    assign stat.in_func  = s_tuser;
    assign stat.step_bad = (cfg.step_size == '0) || (cfg.step_size < cfg.min_step);

    // Restoring divider step: one quotient bit of |x| / step per cycle.
    always_comb begin
        trial    = {rem_reg, quo_reg[SAMPLE_BITS-1]};
        trial_ge = (trial >= {1'b0, cfg.step_size});
        rem_next = trial_ge ? STEP_BITS'(trial - {1'b0, cfg.step_size})
                            : trial[STEP_BITS-1:0];
        quo_next = {quo_reg[SAMPLE_BITS-2:0], trial_ge};
    end

    // Mode decode shared by the symbol and index steps.
    assign both_zero   = (cfg.min_index == '0) && (cfg.max_index == '0);
    assign offset_mode = !cfg.min_index[INDEX_BITS-1];
    assign x_neg       = x_reg[SAMPLE_BITS-1];

    // Symbol from the quotient, clamped to the symbol range.
    always_comb begin
        q_w    = signed'(SVW'(quo_reg));
        imin_w = SVW'(signed'(cfg.min_index));
        imax_w = signed'(SVW'(cfg.max_index));
        if (offset_mode) begin
            sv = (x_neg ? -q_w : q_w) - imin_w;
        end else if (q_w == '0) begin
            sv = '0;
        end else if (x_neg) begin
            sv = q_w + imax_w - SVW'(1);
        end else begin
            sv = q_w;
        end
        if (sv[SVW-1]) begin
            sym_q = '0;
        end else if (|sv[SVW-2:SYMBOL_BITS]) begin
            sym_q = '1;
        end else begin
            sym_q = sv[SYMBOL_BITS-1:0];
        end
        if (func_reg == FUNC_DEQUANT) begin
            sym_next = symin_reg;
        end else begin
            sym_next = both_zero ? '0 : sym_q;
        end
    end

    // Reconstruction index: offset, plain, or folded negative half.
    always_comb begin
        s_k        = signed'(KW'(sym_reg));
        imin_k     = KW'(signed'(cfg.min_index));
        imax_k     = signed'(KW'(cfg.max_index));
        n_k        = imax_k - imin_k - KW'(1);
        thr_k      = (n_k == '0) ? '0 : ((n_k - KW'(1)) >>> 1);
        vzero_next = both_zero || (!offset_mode && sym_reg == '0);
        neg_next   = 1'b0;
        if (offset_mode) begin
            k_next = s_k + imin_k;
        end else if (s_k > thr_k) begin
            k_next   = s_k + KW'(1) - imax_k;
            neg_next = 1'b1;
        end else begin
            k_next = s_k;
        end
    end

    // Midpoint product (2k+1) * step.
    assign odd_w     = {k_reg, 1'b1};
    assign step_w    = signed'({1'b0, cfg.step_size});
    assign prod_next = odd_w * step_w;

    // Halve toward minus infinity, apply sign, saturate to the sample range.
    always_comb begin
        mp      = prod_reg >>> 1;
        val     = neg_reg ? -mp : mp;
        val_top = val[PW-1:SAMPLE_BITS-1];
        if ((&val_top) || (~|val_top)) begin
            v_sat = val[SAMPLE_BITS-1:0];
        end else if (val[PW-1]) begin
            v_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            v_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
        v_next = vzero_reg ? '0 : v_sat;
    end

    // Absolute error and its square.
    assign d_w     = {x_reg[SAMPLE_BITS-1], x_reg} - {v_reg[SAMPLE_BITS-1], v_reg};
    assign ad_w    = d_w[DW-1] ? (~d_w + 1'b1) : d_w;
    assign ad_lo   = ad_reg[30:0];
    assign sq_next = ad_lo * ad_lo;

    // Saturating accumulation of the squared error.
    always_comb begin
        sum_w = {1'b0, acc_reg} + {1'b0, sq_reg};
        if (func_reg == FUNC_DEQUANT) begin
            acc_new = acc_reg;
        end else if (rej_reg || big_reg || sum_w[DIST_BITS]) begin
            acc_new = DIST_MAX;
        end else begin
            acc_new = sum_w[DIST_BITS-1:0];
        end
    end

    // Result fields forced to zero: the symbol for a rejected or dequantize request, the value for a rejected one.
    assign sym_out = (func_reg == FUNC_DEQUANT || rej_reg) ? '0 : sym_reg;
    assign v_out   = rej_reg ? '0 : v_reg;

    // Datapath registers, each advanced by its own command.
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            func_reg  <= s_tuser;
            last_reg  <= s_tlast;
            x_reg     <= in_sample;
            symin_reg <= in_symbol;
            rej_reg   <= (s_tuser == FUNC_QUANT) && stat.step_bad;
            rem_reg   <= '0;
            quo_reg   <= in_mag;
        end
        if (cmd.div_step) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
        if (cmd.sym_step) begin
            sym_reg <= sym_next;
        end
        if (cmd.ksel_step) begin
            k_reg     <= k_next;
            vzero_reg <= vzero_next;
            neg_reg   <= neg_next;
        end
        if (cmd.mul_step) begin
            prod_reg <= prod_next;
        end
        if (cmd.recon_step) begin
            v_reg <= v_next;
        end
        if (cmd.err_step) begin
            ad_reg <= 33'(ad_w);
        end
        if (cmd.sq_step) begin
            sq_reg  <= sq_next;
            big_reg <= |ad_reg[32:31];
        end
        if (cmd.acc_step) begin
            dist_reg <= acc_new;
        end
        if (cmd.out_load) begin
            m_tdata_reg <= OUT_W'({dist_reg, v_out, sym_out});
            m_tuser_reg <= rej_reg;
            m_tlast_reg <= last_reg && (func_reg == FUNC_QUANT);
        end
    end

    // Error accumulator; cleared after the last quantize request of a block.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else if (cmd.acc_step) begin
            acc_reg <= (last_reg && func_reg == FUNC_QUANT) ? '0 : acc_new;
        end
    end

    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;
    assign m_tlast = m_tlast_reg;

    // The partial remainder stays below the divisor during division.
    `UQD_ASSERT(a_rem_below_step, aclk, aresetn, cmd.div_step, (rem_reg < cfg.step_size))
    // A rejected quantize request reports a saturated sum.
    `UQD_ASSERT_NEXT(a_reject_saturates, aclk, aresetn, (cmd.acc_step && rej_reg),
        (dist_reg == DIST_MAX))
    // The end of a block leaves the accumulator empty.
    `UQD_ASSERT_NEXT(a_block_clears, aclk, aresetn,
        (cmd.acc_step && last_reg && func_reg == FUNC_QUANT), (acc_reg == '0))

endmodule

@@ design/uniform_quantize_dequantize_unit.sv @@
// Top level of the uniform quantize/dequantize unit.
// Instantiates uqd_regs, uqd_ctrl and uqd_dp; depends on uqd_pkg.
//
// The unit takes one request at a time on the s_ stream and returns one result on
// the m_ stream. A quantize request (s_tuser = 0) divides the sample magnitude by
// step_size with a restoring divider that produces one quotient bit per clock. A
// dequantize request (s_tuser = 1) skips the divider, and a quantize request with
// a step below min_step, or zero, skips straight to the accumulate step. A finished
// result is held in an output register, so the next request is accepted while the
// previous result waits. The squared-error sum on m_tdata saturates, m_tlast marks
// the total of a block, and the accumulator restarts after it. Registers are to be
// written over the APB-style port only while the unit is idle; the unit itself
// does not enforce this.
module uniform_quantize_dequantize_unit #(
    parameter int SAMPLE_BITS = uqd_pkg::SAMPLE_BITS_DEF,
    parameter int SYMBOL_BITS = uqd_pkg::SYMBOL_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // Request stream
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // s_tdata: sample, symbol_in (lowest bit first), zero padded
    input  logic [((SAMPLE_BITS + SYMBOL_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // s_tuser: func
    input  logic                                   s_tuser,
    input  logic                                   s_tlast,
    // Result stream
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // m_tdata: symbol_out, value, distortion_sum (lowest bit first), zero padded
    output logic [((SYMBOL_BITS + SAMPLE_BITS + uqd_pkg::DIST_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    // m_tuser: rejected
    output logic                                   m_tuser,
    output logic                                   m_tlast,
    // Configuration port
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [uqd_pkg::CFG_ADDR_BITS-1:0]      paddr,
    input  logic [uqd_pkg::CFG_DATA_BITS-1:0]      pwdata,
    output logic [uqd_pkg::CFG_DATA_BITS-1:0]      prdata,
    output logic                                   pready
);
    import uqd_pkg::*;

    uqd_cfg_t  cfg;
    uqd_cmd_t  cmd;
    uqd_stat_t stat;

    // Configuration registers.
    uqd_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencer.
    uqd_ctrl #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Arithmetic and result register.
    uqd_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .cmd     (cmd),
        .stat    (stat),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

endmodule

@@ tb/uniform_quantize_dequantize_unit_tb.sv @@
// Self-checking testbench for uniform_quantize_dequantize_unit.
// Drives quantize and dequantize requests and APB register writes, predicts every result
// in-house, and compares it field by field. Depends on uqd_pkg and the design sources.
module uniform_quantize_dequantize_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import uqd_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int MAX_REPORTS    = 200;
    localparam int DRAIN_CYCLES   = 60;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_REQUESTS = 44;

    // One result as it appears on the m_ stream.
    typedef struct packed {
        logic [15:0] sym;
        logic [23:0] val;
        logic [61:0] dsum;
        logic        rej;
        logic        done;
    } qd_result_t;

    // One row of the directed table: a register write or a request.
    typedef struct {
        bit          is_cfg;
        logic [1:0]  reg_sel;
        bit   [31:0] reg_val;
        logic        func;
        bit   [23:0] sample;
        bit   [15:0] symbol;
        bit          last;
        bit          typed;
        bit   [15:0] t_sym;
        bit   [23:0] t_val;
        bit          t_rej;
    } dir_row_t;

    logic          aclk;
    logic          aresetn;
    logic          s_tvalid;
    logic          s_tready;
    // s_tdata: sample [23:0], symbol_in [39:24]
    logic [39:0]   s_tdata;
    // s_tuser: func
    logic          s_tuser;
    logic          s_tlast;
    logic          m_tvalid;
    logic          m_tready;
    // m_tdata: symbol_out [15:0], value [39:16], distortion_sum [101:40], zero pad above
    logic [103:0]  m_tdata;
    // m_tuser: rejected
    logic          m_tuser;
    logic          m_tlast;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [3:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;

    // Predictor copy of the registers and the squared-error accumulator.
    bit        [22:0] cur_step;
    bit        [22:0] cur_min_step;
    bit        [14:0] cur_max_idx;
    bit signed [15:0] cur_min_idx;
    bit        [61:0] acc_sq_error;

    qd_result_t pending_results[$];
    dir_row_t   dir_rows[$];
    qd_result_t rx_got;
    qd_result_t rx_want;
    int         fail_count;
    int         report_count;
    int         cycle_count;
    int         sender_idle_pct;
    int         recv_stall_pct;

    uniform_quantize_dequantize_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Clock with a 20 ns period.
    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // Midpoint (k + 0.5) * step, rounded toward minus infinity.
    function automatic longint mid_point(longint k);
        longint t;
        t = (2 * k + 1) * longint'(cur_step);
        if (t >= 0) begin
            return t / 2;
        end
        return -((-t + 1) / 2);
    endfunction

    // Clamp a reconstruction to the 24-bit sample range.
    function automatic longint sat_sample(longint v);
        if (v > 64'sd8388607) begin
            return 64'sd8388607;
        end
        if (v < -64'sd8388608) begin
            return -64'sd8388608;
        end
        return v;
    endfunction

    // Reconstruction value of a symbol under the current index range.
    function automatic longint recon_of(longint s);
        longint imin;
        longint imax;
        longint n;
        longint thr;
        imin = longint'(cur_min_idx);
        imax = longint'(cur_max_idx);
        if (imin == 0 && imax == 0) begin
            return 0;
        end
        if (imin >= 0) begin
            return sat_sample(mid_point(s + imin));
        end
        if (s == 0) begin
            return 0;
        end
        n = imax - imin - 1;
        if (n < 0) begin
            n = 0;
        end
        thr = (n == 0) ? 0 : (n - 1) / 2;
        if (s > thr) begin
            return sat_sample(-mid_point(s + 1 - imax));
        end
        return sat_sample(mid_point(s));
    endfunction

    // Quantization symbol of a sample, clamped to the symbol range.
    function automatic longint symbol_of(longint x);
        longint imin;
        longint imax;
        longint st;
        longint mag;
        longint q;
        longint s;
        imin = longint'(cur_min_idx);
        imax = longint'(cur_max_idx);
        st   = longint'(cur_step);
        mag  = (x < 0) ? -x : x;
        q    = mag / st;
        if (imin == 0 && imax == 0) begin
            return 0;
        end
        if (imin >= 0) begin
            s = ((x < 0) ? -q : q) - imin;
        end else if (mag < st) begin
            s = 0;
        end else begin
            s = (x > 0) ? q : q + imax - 1;
        end
        if (s < 0) begin
            s = 0;
        end
        if (s > 65535) begin
            s = 65535;
        end
        return s;
    endfunction

    // Result of one accepted request; a quantize request updates the accumulator.
    function automatic qd_result_t compute_quant_result(logic func, bit [23:0] sample,
                                                        bit [15:0] sym_in, bit last);
        qd_result_t  res;
        longint      x;
        longint      s;
        longint      v;
        longint      d;
        logic [63:0] ad;
        logic [63:0] sum;
        bit          reject;
        res = '0;
        x   = longint'(signed'(sample));
        if (func == FUNC_DEQUANT) begin
            v        = recon_of(longint'(sym_in));
            res.val  = v[23:0];
            res.dsum = acc_sq_error;
            return res;
        end
        s = 0;
        v = 0;
        reject = (cur_step == 0) || (cur_step < cur_min_step);
        if (reject) begin
            acc_sq_error = DIST_MAX;
        end else begin
            s  = symbol_of(x);
            v  = recon_of(s);
            d  = x - v;
            ad = (d < 0) ? 64'(-d) : 64'(d);
            if (ad > 64'h7FFF_FFFF) begin
                acc_sq_error = DIST_MAX;
            end else begin
                sum = {2'b00, acc_sq_error} + ad * ad;
                acc_sq_error = (sum > {2'b00, DIST_MAX}) ? DIST_MAX : sum[61:0];
            end
        end
        res.sym  = s[15:0];
        res.val  = v[23:0];
        res.dsum = acc_sq_error;
        res.rej  = reject;
        res.done = last;
        if (last) begin
            acc_sq_error = '0;
        end
        return res;
    endfunction

    function automatic dir_row_t cfg_row(logic [1:0] sel, bit [31:0] val);
        dir_row_t r;
        r = '{default: '0};
        r.is_cfg  = 1'b1;
        r.reg_sel = sel;
        r.reg_val = val;
        return r;
    endfunction

    function automatic dir_row_t item_row(logic func, bit [23:0] sample, bit [15:0] symbol,
                                          bit last);
        dir_row_t r;
        r = '{default: '0};
        r.func   = func;
        r.sample = sample;
        r.symbol = symbol;
        r.last   = last;
        return r;
    endfunction

    // Request row whose symbol, value and rejected flag are known directly.
    function automatic dir_row_t typed_row(logic func, bit [23:0] sample, bit [15:0] symbol,
                                           bit last, bit [15:0] e_sym, bit [23:0] e_val,
                                           bit e_rej);
        dir_row_t r;
        r = item_row(func, sample, symbol, last);
        r.typed = 1'b1;
        r.t_sym = e_sym;
        r.t_val = e_val;
        r.t_rej = e_rej;
        return r;
    endfunction

    // Present one request after a random gap and wait until it is taken.
    task automatic send_req(logic func, bit [23:0] sample, bit [15:0] sym, bit last);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tlast  <= last;
        s_tdata  <= {sym, sample};
        do @(posedge aclk); while (s_tready !== 1'b1);
    endtask

    // Stop sending and wait until every expected result has come back.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // APB write: setup phase, access phase, then idle before returning.
    task automatic apb_write(logic [1:0] sel, bit [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (sel)
            REG_STEP_SIZE: cur_step     = val[22:0];
            REG_MIN_STEP:  cur_min_step = val[22:0];
            REG_MAX_INDEX: cur_max_idx  = val[14:0];
            default:       cur_min_idx  = val[15:0];
        endcase
        @(posedge aclk);
    endtask

    // Result checker and receiver back-pressure.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            rx_got.sym  = m_tdata[15:0];
            rx_got.val  = m_tdata[39:16];
            rx_got.dsum = m_tdata[101:40];
            rx_got.rej  = m_tuser;
            rx_got.done = m_tlast;
            if (pending_results.size() == 0) begin
                fail_count++;
                if (report_count < MAX_REPORTS) begin
                    report_count++;
                    $display("%0t ns: unexpected result sym %h value %h dist %h rej %b done %b",
                             $time, rx_got.sym, rx_got.val, rx_got.dsum, rx_got.rej,
                             rx_got.done);
                end
            end else begin
                rx_want = pending_results.pop_front();
                if (rx_got !== rx_want) begin
                    fail_count++;
                    if (report_count < MAX_REPORTS) begin
                        report_count++;
                        $display({"%0t ns: mismatch, expected sym %h value %h dist %h rej %b ",
                                  "done %b, got sym %h value %h dist %h rej %b done %b"},
                                 $time, rx_want.sym, rx_want.val, rx_want.dsum, rx_want.rej,
                                 rx_want.done, rx_got.sym, rx_got.val, rx_got.dsum,
                                 rx_got.rej, rx_got.done);
                    end
                end
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("uniform_quantize_dequantize_unit test failed");
            $finish;
        end
    end

    // Stimulus: reset, directed table, then randomized phases.
    initial begin
        qd_result_t res;
        dir_row_t   row;
        logic       fn;
        bit  [23:0] smp;
        bit  [15:0] sy;
        bit         lst;
        longint     lim;
        longint     cap;
        int         mi;
        bit  [31:0] v_step;
        bit  [31:0] v_min_step;
        bit  [31:0] v_max_idx;

        aresetn         = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = FUNC_QUANT;
        s_tlast         = 1'b0;
        m_tready        = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        fail_count      = 0;
        report_count    = 0;
        cycle_count     = 0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        cur_step        = STEP_SIZE_RST;
        cur_min_step    = '0;
        cur_max_idx     = '0;
        cur_min_idx     = '0;
        acc_sq_error    = '0;

        // After reset both indexes are zero: every symbol and value is zero.
        dir_rows.push_back(typed_row(FUNC_QUANT, 24'h7FFFFF, 16'hFFFF, 1'b0, 16'h0, 24'h0, 1'b0));
        dir_rows.push_back(typed_row(FUNC_QUANT, 24'h800000, 16'h0000, 1'b1, 16'h0, 24'h0, 1'b0));
        dir_rows.push_back(typed_row(FUNC_DEQUANT, 24'h0, 16'hFFFF, 1'b1, 16'h0, 24'h0, 1'b0));
        // Offset mode from zero; the top symbol saturates the reconstruction.
        dir_rows.push_back(cfg_row(REG_MAX_INDEX, 32'd32767));
        dir_rows.push_back(item_row(FUNC_QUANT, 24'h7FFFFF, 16'h0, 1'b0));
        dir_rows.push_back(item_row(FUNC_QUANT, 24'h800000, 16'h0, 1'b0));
        dir_rows.push_back(item_row(FUNC_QUANT, 24'(300), 16'h0, 1'b1));
        dir_rows.push_back(item_row(FUNC_DEQUANT, 24'h0, 16'h0000, 1'b0));
        dir_rows.push_back(item_row(FUNC_DEQUANT, 24'h0, 16'hFFFF, 1'b0));
        // Largest positive minimum index.
        dir_rows.push_back(cfg_row(REG_MIN_INDEX, 32'd32767));
        dir_rows.push_back(item_row(FUNC_QUANT, 24'h7FFFFF, 16'h0, 1'b0));
        dir_rows.push_back(item_row(FUNC_DEQUANT, 24'h0, 16'hFFFF, 1'b0));
        // Sign-folded mode: dead zone, both signs, both sides of the threshold.
        dir_rows.push_back(cfg_row(REG_MIN_INDEX, 32'h0000_8001));
        dir_rows.push_back(typed_row(FUNC_QUANT, 24'(100), 16'h0, 1'b0, 16'h0, 24'h0, 1'b0));
        dir_rows.push_back(item_row(FUNC_QUANT, 24'h7FFFFF, 16'h0, 1'b0));
        dir_rows.push_back(item_row(FUNC_QUANT, 24'h800000, 16'h0, 1'b0));
        dir_rows.push_back(item_row(FUNC_QUANT, 24'(-300), 16'h0, 1'b1));
        dir_rows.push_back(typed_row(FUNC_DEQUANT, 24'h0, 16'h0, 1'b0, 16'h0, 24'h0, 1'b0));
        dir_rows.push_back(item_row(FUNC_DEQUANT, 24'h0, 16'd40000, 1'b0));
        dir_rows.push_back(item_row(FUNC_DEQUANT, 24'h0, 16'd5, 1'b0));
        // Smallest and largest step.
        dir_rows.push_back(cfg_row(REG_STEP_SIZE, 32'd1));
        dir_rows.push_back(item_row(FUNC_QUANT, 24'h7FFFFF, 16'h0, 1'b0));
        dir_rows.push_back(item_row(FUNC_QUANT, 24'hFFFFFF, 16'h0, 1'b1));
        dir_rows.push_back(cfg_row(REG_STEP_SIZE, 32'd8388607));
        dir_rows.push_back(item_row(FUNC_QUANT, 24'h7FFFFF, 16'h0, 1'b0));
        // Step equal to the minimum passes, a zero or smaller step is rejected.
        dir_rows.push_back(cfg_row(REG_MIN_STEP, 32'd8388607));
        dir_rows.push_back(item_row(FUNC_QUANT, 24'h800000, 16'h0, 1'b0));
        dir_rows.push_back(cfg_row(REG_STEP_SIZE, 32'd0));
        dir_rows.push_back(typed_row(FUNC_QUANT, 24'(1234), 16'h0, 1'b0, 16'h0, 24'h0, 1'b1));
        dir_rows.push_back(cfg_row(REG_STEP_SIZE, 32'd1));
        dir_rows.push_back(typed_row(FUNC_QUANT, 24'h7FFFFF, 16'h0, 1'b1, 16'h0, 24'h0, 1'b1));
        dir_rows.push_back(item_row(FUNC_DEQUANT, 24'h0, 16'd5, 1'b0));
        dir_rows.push_back(cfg_row(REG_MIN_STEP, 32'd0));

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table, no idling on either side.
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.is_cfg) begin
                settle();
                apb_write(row.reg_sel, row.reg_val);
            end else begin
                send_req(row.func, row.sample, row.symbol, row.last);
                res = compute_quant_result(row.func, row.sample, row.symbol, row.last);
                if (row.typed) begin
                    res.sym = row.t_sym;
                    res.val = row.t_val;
                    res.rej = row.t_rej;
                end
                pending_results.push_back(res);
            end
        end

        // Random phases: new register settings and a new idling pattern each time.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            settle();
            case (ph % 4)
                0: begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 0;
                end
                1: begin
                    sender_idle_pct = 57;
                    recv_stall_pct  = 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 57;
                end
                default: begin
                    sender_idle_pct = 32;
                    recv_stall_pct  = 32;
                end
            endcase
            v_min_step = 32'd0;
            v_max_idx  = $urandom_range(0, 32767);
            case (ph % 6)
                0: begin
                    v_step = $urandom_range(1, 4096);
                    mi     = int'($urandom_range(0, 65534)) - 32767;
                end
                1: begin
                    // Sign-folded; the first time with a tiny index range.
                    v_step = $urandom_range(1, 2048);
                    if (ph < 6) begin
                        v_max_idx = 32'd0;
                        mi        = -int'($urandom_range(1, 3));
                    end else begin
                        mi = -int'($urandom_range(1, 32767));
                    end
                end
                2: begin
                    v_step = $urandom_range(1, 2048);
                    mi     = int'($urandom_range(0, 200));
                end
                3: begin
                    // Both indexes zero.
                    v_step    = $urandom_range(1, 8388607);
                    v_max_idx = 32'd0;
                    mi        = 0;
                end
                4: begin
                    // Step random over the full range, minimum step over all nonzero values.
                    v_step     = $urandom_range(0, 8388607);
                    v_min_step = $urandom_range(1, 8388607);
                    mi         = int'($urandom_range(0, 65534)) - 32767;
                end
                default: begin
                    v_step    = (ph < 6) ? 32'd1 : 32'd8388607;
                    v_max_idx = 32'd32767;
                    mi        = (ph < 6) ? -32767 : 32767;
                end
            endcase
            apb_write(REG_STEP_SIZE, v_step);
            apb_write(REG_MIN_STEP, v_min_step);
            apb_write(REG_MAX_INDEX, v_max_idx);
            apb_write(REG_MIN_INDEX, {16'h0000, 16'(mi)});

            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                fn  = ($urandom_range(3) == 0) ? FUNC_DEQUANT : FUNC_QUANT;
                lst = ($urandom_range(7) == 0);
                // Samples: full range, near the step grid, or the range ends, zero and plus or minus one step.
                case ($urandom_range(3))
                    0, 1: smp = 24'($urandom);
                    2: begin
                        lim = longint'(cur_step) * 64;
                        if (lim > 8388607) begin
                            lim = 8388607;
                        end
                        smp = 24'(longint'($urandom_range(0, 32'(2 * lim))) - lim);
                    end
                    default: begin
                        case ($urandom_range(4))
                            0: smp = 24'h7FFFFF;
                            1: smp = 24'h800000;
                            2: smp = 24'h000000;
                            3: smp = 24'(cur_step);
                            default: smp = 24'(-longint'(cur_step));
                        endcase
                    end
                endcase
                // Symbols: full range, or within the index range.
                if ($urandom_range(1) == 0) begin
                    sy = 16'($urandom);
                end else begin
                    cap = 2 * longint'(cur_max_idx) + 2;
                    if (cap > 65535) begin
                        cap = 65535;
                    end
                    sy = 16'($urandom_range(0, 32'(cap)));
                end
                send_req(fn, smp, sy, lst);
                pending_results.push_back(compute_quant_result(fn, smp, sy, lst));
            end
        end

        // Drain, then give the unit time to show any extra result.
        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("uniform_quantize_dequantize_unit test passed");
        end else begin
            $display("uniform_quantize_dequantize_unit test failed");
        end
        $finish;
    end

endmodule
